@@ src/u2a_pkg.sv @@
// ----------------------------------------------------------------------------
// u2a_pkg
// Shared types, constants and helpers for the radix conversion block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package u2a_pkg;

    localparam int VALUE_W        = 32;
    localparam int MAX_DIGITS_DEF = 11;
    localparam int DIGIT_W        = 4;
    localparam int CHAR_W         = 8;
    localparam int COUNT_W        = 32;

    typedef enum logic [1:0] {
        FUNC_DEC    = 2'd0,
        FUNC_OCT    = 2'd1,
        FUNC_HEX_LO = 2'd2,
        FUNC_HEX_UP = 2'd3
    } t_func;

    // Status the conversion unit reports to the output stage.
    typedef struct packed {
        logic               idle;
        logic               avail;
        logic [DIGIT_W-1:0] digit;
        logic               last;
    } t_conv_stat;

    localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(
        input logic [DIGIT_W-1:0] digit,
        input logic               lower
    );
        logic [CHAR_W-1:0] ext;
        ext = {{(CHAR_W-DIGIT_W){1'b0}}, digit};
        if (digit < 4'd10) begin
            return ASCII_ZERO + ext;
        end else if (lower) begin
            return ASCII_LOWER_A + ext - 8'd10;
        end else begin
            return ASCII_UPPER_A + ext - 8'd10;
        end
    endfunction

endpackage

`default_nettype wire

@@ src/u2a_conv.sv @@
// ----------------------------------------------------------------------------
// u2a_conv
// Digit unit: splits a value into radix digits (shift-and-add-three for
// decimal, bit slicing for octal and hex), strips leading zeros and then
// hands the digits out one at a time, most significant first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u2a_conv #(
    parameter int MAX_DIGITS = u2a_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [u2a_pkg::VALUE_W-1:0]  i_value,
    input  wire logic [1:0]                   i_func,
    input  wire logic                         i_pop,
    output u2a_pkg::t_conv_stat               o_stat
);
    import u2a_pkg::*;

    localparam int DW    = MAX_DIGITS * DIGIT_W;
    localparam int LW    = $clog2(MAX_DIGITS + 1);
    localparam int CNT_W = $clog2(VALUE_W);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DABBLE = 4'b0010,
        S_SKIP   = 4'b0100,
        S_EMIT   = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [DW-1:0]      r_dig, n_dig;
    logic [VALUE_W-1:0] r_bin, n_bin;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [LW-1:0]      r_left, n_left;

    logic [DW-1:0]      w_ext;
    logic [DW-1:0]      w_oct;
    logic [DW-1:0]      w_adj;
    logic [DIGIT_W-1:0] w_top;

    assign w_ext = {{(DW-VALUE_W){1'b0}}, i_value};
    assign w_top = r_dig[DW-1 -: DIGIT_W];

    always_comb begin
        w_oct = '0;
        w_adj = '0;
        for (int k = 0; k < MAX_DIGITS; k++) begin
            w_oct[k*DIGIT_W +: DIGIT_W] = {1'b0, w_ext[k*3 +: 3]};
            // Correct any BCD digit that would overflow when doubled.
            if (r_dig[k*DIGIT_W +: DIGIT_W] >= 4'd5) begin
                w_adj[k*DIGIT_W +: DIGIT_W] = r_dig[k*DIGIT_W +: DIGIT_W] + 4'd3;
            end else begin
                w_adj[k*DIGIT_W +: DIGIT_W] = r_dig[k*DIGIT_W +: DIGIT_W];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_dig   = r_dig;
        n_bin   = r_bin;
        n_cnt   = r_cnt;
        n_left  = r_left;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_left = LW'(MAX_DIGITS);
                    n_cnt  = '0;
                    n_bin  = i_value;
                    if (i_func == FUNC_DEC) begin
                        n_dig   = '0;
                        n_state = S_DABBLE;
                    end else if (i_func == FUNC_OCT) begin
                        n_dig   = w_oct;
                        n_state = S_SKIP;
                    end else begin
                        n_dig   = w_ext;
                        n_state = S_SKIP;
                    end
                end
            end
            S_DABBLE: begin
                n_dig = {w_adj[DW-2:0], r_bin[VALUE_W-1]};
                n_bin = {r_bin[VALUE_W-2:0], 1'b0};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(VALUE_W - 1)) begin
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                // A zero value keeps its final digit.
                if (w_top == '0 && r_left > LW'(1)) begin
                    n_dig  = {r_dig[DW-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    n_left = r_left - LW'(1);
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_pop) begin
                    n_dig  = {r_dig[DW-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    n_left = r_left - LW'(1);
                    if (r_left == LW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_left  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dig <= n_dig;
        r_bin <= n_bin;
    end

    assign o_stat.idle  = (r_state == S_IDLE);
    assign o_stat.avail = (r_state == S_EMIT);
    assign o_stat.digit = w_top;
    assign o_stat.last  = (r_left == LW'(1));

endmodule

`default_nettype wire

@@ src/unsigned_to_ascii_radix.sv @@
// ----------------------------------------------------------------------------
// unsigned_to_ascii_radix
// Converts a 32-bit unsigned value to ASCII decimal, octal or hex digits,
// most significant first, with a running count of characters emitted.
// ----------------------------------------------------------------------------
// Sequence: a decimal item runs through the shift-and-add-three loop, octal and
// hex items skip it; leading zeros (up to MAX_DIGITS-1) are then stripped and
// each digit is registered as a character, one a cycle while i_stall is low.
// o_stall stays high from the accepted item until its final digit is taken, so
// a new item is accepted only once the digit unit has handed out the last one.
// Reset clears the sequencer, output valid and the character count.
`timescale 1ns / 1ps
`default_nettype none

module unsigned_to_ascii_radix #(
    parameter int MAX_DIGITS = u2a_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [u2a_pkg::VALUE_W-1:0]  i_value,
    input  wire logic [1:0]                   i_func,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [u2a_pkg::CHAR_W-1:0]        o_char_code,
    output logic                              o_last_char,
    output logic [u2a_pkg::COUNT_W-1:0]       o_total_emitted
);
    import u2a_pkg::*;

    t_conv_stat         w_stat;
    logic               w_accept;
    logic               w_pop;
    logic               r_lower;
    logic               r_valid;
    logic [COUNT_W-1:0] r_total;
    logic [CHAR_W-1:0]  r_char;
    logic               r_last;

    assign o_stall  = !w_stat.idle;
    assign w_accept = i_valid && w_stat.idle;
    // The output register takes a new digit whenever it is empty or drained.
    assign w_pop    = w_stat.avail && (!r_valid || !i_stall);

    u2a_conv #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_value (i_value),
        .i_func  (i_func),
        .i_pop   (w_pop),
        .o_stat  (w_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_total <= '0;
        end else begin
            if (w_pop) begin
                r_valid <= 1'b1;
                r_total <= r_total + COUNT_W'(1);
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_lower <= (i_func == FUNC_HEX_LO);
        end
        if (w_pop) begin
            r_char <= digit_to_ascii(w_stat.digit, r_lower);
            r_last <= w_stat.last;
        end
    end

    assign o_valid         = r_valid;
    assign o_char_code     = r_char;
    assign o_last_char     = r_last;
    assign o_total_emitted = r_total;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_stall)
        else $error("digit unit did not start on an input transfer");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && w_stat.last) |=> !o_stall)
        else $error("digit unit still busy after its final digit");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> (o_valid && o_total_emitted == $past(o_total_emitted) + COUNT_W'(1)))
        else $error("character count did not advance with a digit");

endmodule

`default_nettype wire
